// ===== hdl/mirc_pkg.sv =====
package mirc_pkg;

  localparam int MAX_TERMS   = 32;
  localparam int MAX_RESULTS = 32;
  // address, count and kept-count widths
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int NW = $clog2(MAX_RESULTS + 1);

  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;

  localparam logic [30:0] TOL_RESET = 31'd4295;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MODE      = 2'd0;
  localparam cfg_idx_t CFG_MAX_CUTS  = 2'd1;
  localparam cfg_idx_t CFG_TOLERANCE = 2'd2;

  // one stored term; after the rounding pass coeff holds the cut
  // coefficient and int_flag marks a kept term
  typedef struct packed {
    logic [31:0]        var_id;
    logic signed [63:0] coeff;
    logic signed [63:0] bound;
    logic               int_flag;
    logic signed [63:0] lp_value;
  } term_t;

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sadd = s[64] ? Q_MIN : Q_MAX;
    end else begin
      sadd = s[63:0];
    end
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      ssub = s[64] ? Q_MIN : Q_MAX;
    end else begin
      ssub = s[63:0];
    end
  endfunction

  function automatic logic signed [63:0] sneg(input logic signed [63:0] a);
    sneg = (a == Q_MIN) ? Q_MAX : -a;
  endfunction

endpackage

// ===== hdl/mixed_integer_rounding_cut.sv =====
// Mixed-integer rounding cut generator.
// Input channel (in_valid_i/in_ready_o) takes one row term per item; the
// row ends with last_term_i. Output channel (out_valid_o/out_ready_i) gives
// one item per cut term, cut_last_o on the final one. Configuration writes
// (cfg_valid_i, cfg_index_i, cfg_data_i) are always taken: index 0 mode,
// 1 max_cuts, 2 tolerance.
// Terms are held in one 225-bit x 32 RAM. Each term is stored on input and
// uses the shared 32x32 multiplier when its bound shift still matters for
// the row. At row end each stored term is read back, rounded, through the
// bit-serial divider where needed, written back with its keep mark, and
// kept terms take two more multiplies. An emitted cut then rereads the RAM
// and gives one item per kept term, held while the receiver stalls.
// One row is processed at a time; input is not taken until every cut item
// is delivered. A stalled receiver holds the output register and the pass.
// Reset clears the row, the cut counter and the registers to their
// defaults; RAM contents need no clearing as only written entries are read.
module mixed_integer_rounding_cut (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // term input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        var_id_i,
  input  logic signed [63:0] term_coeff_i,
  input  logic signed [63:0] var_bound_i,
  input  logic               bound_infinite_i,
  input  logic               is_integer_i,
  input  logic signed [63:0] lp_value_i,
  input  logic signed [63:0] row_rhs_i,
  input  logic [1:0]         row_sense_i,
  input  logic               last_term_i,
  input  logic               new_pass_i,
  // cut output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        cut_var_o,
  output logic signed [63:0] cut_coeff_o,
  output logic signed [63:0] cut_rhs_o,
  output logic               cut_last_o
);

  localparam int AW = mirc_pkg::AW;
  localparam int CW = mirc_pkg::CW;
  localparam int NW = mirc_pkg::NW;

  typedef enum logic [3:0] {
    S_IDLE, S_TMUL, S_CHECK, S_RD, S_ALPHA, S_DIVW, S_KEEP,
    S_M1, S_M2, S_VIOL, S_ERD, S_ECHK, S_EOUT
  } state_e;

  state_e             state_q;
  logic               mode_q;
  logic [15:0]        max_cuts_q;
  logic [30:0]        tol_q;
  logic [CW-1:0]      term_count_q;
  logic signed [63:0] shifted_q;
  logic               skip_q;
  logic [15:0]        cuts_made_q;
  logic               last_q;
  logic [31:0]        f_q;
  logic signed [63:0] rhs_q, lhs_q, alpha_q;
  logic               add_floor_q;
  logic [CW-1:0]      idx_q;
  logic [CW-1:0]      last_keep_q;
  logic [NW-1:0]      nkeep_q;
  logic               out_valid_q;
  logic [31:0]        cut_var_q;
  logic signed [63:0] cut_coeff_q;
  logic               cut_last_q;

  // RAM port signals
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  mirc_pkg::term_t            wr_word, rd_word;
  logic [$bits(mirc_pkg::term_t)-1:0] ram_rdata;

  // arithmetic unit signals
  logic               mul_start, mul_done;
  logic signed [63:0] mul_a, mul_b, mul_p;
  logic               div_start, div_done;
  logic [63:0]        div_num, div_den;
  logic signed [63:0] div_q;

  // per-term and row-end decisions
  logic               accept_in, full, skip_new, do_mul;
  logic signed [63:0] base_rhs, tol_s, floor_sh, floor_a;
  logic               row_drop, keep, abort_cut, idx_last, viol, emit_last;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept_in   = in_valid_i && in_ready_o;
  assign rd_word     = mirc_pkg::term_t'(ram_rdata);
  assign tol_s       = {33'b0, tol_q};

  always_comb begin
    full     = (term_count_q >= CW'(mirc_pkg::MAX_TERMS));
    skip_new = skip_q || full || bound_infinite_i ||
               (row_sense_i != {1'b0, mode_q}) ||
               (mode_q && (term_coeff_i <= 64'sd0));
    do_mul   = !skip_new;
    if (term_count_q == '0) begin
      base_rhs = mode_q ? mirc_pkg::sneg(row_rhs_i) : row_rhs_i;
    end else begin
      base_rhs = shifted_q;
    end

    floor_sh = {shifted_q[63:32], 32'b0};
    row_drop = skip_q ||
               ((max_cuts_q != '0) && (cuts_made_q >= max_cuts_q)) ||
               (mode_q && shifted_q[63]) ||
               ({1'b0, shifted_q[31:0]} <= {2'b0, tol_q}) ||
               ({1'b0, shifted_q[31:0]} >= (33'h1_0000_0000 - {2'b0, tol_q}));

    floor_a   = {rd_word.coeff[63:32], 32'b0};
    keep      = (alpha_q > tol_s);
    abort_cut = keep && (nkeep_q == NW'(mirc_pkg::MAX_RESULTS));
    idx_last  = (CW'(idx_q + CW'(1)) == term_count_q);
    emit_last = (idx_q == last_keep_q);
    if (mode_q) begin
      viol = (lhs_q < mirc_pkg::ssub(rhs_q, tol_s));
    end else begin
      viol = (lhs_q > mirc_pkg::sadd(rhs_q, tol_s));
    end
  end

  // RAM access: term store on input, keep mark on write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = term_count_q[AW-1:0];
    wr_word   = '{var_id: var_id_i, coeff: term_coeff_i, bound: var_bound_i,
                  int_flag: is_integer_i, lp_value: lp_value_i};
    if (accept_in && !full) begin
      ram_we = 1'b1;
    end else if (state_q == S_KEEP) begin
      ram_we           = 1'b1;
      ram_waddr        = idx_q[AW-1:0];
      wr_word          = rd_word;
      wr_word.coeff    = alpha_q;
      wr_word.int_flag = keep;
    end
    ram_re    = (state_q == S_RD) || (state_q == S_ERD);
    ram_raddr = idx_q[AW-1:0];
  end

  // multiplier and divider operand select
  always_comb begin
    mul_start = 1'b0;
    mul_a     = term_coeff_i;
    mul_b     = var_bound_i;
    if (accept_in && do_mul) begin
      mul_start = 1'b1;
    end else if (state_q == S_KEEP && keep && !abort_cut) begin
      mul_start = 1'b1;
      mul_a     = alpha_q;
      mul_b     = rd_word.bound;
    end else if (state_q == S_M1 && mul_done) begin
      mul_start = 1'b1;
      mul_a     = alpha_q;
      mul_b     = rd_word.lp_value;
    end

    div_start = 1'b0;
    div_num   = rd_word.coeff;
    div_den   = {32'b0, f_q};
    if (state_q == S_ALPHA && !rd_word.coeff[63]) begin
      if (!rd_word.int_flag) begin
        div_start = 1'b1;
      end else if (rd_word.coeff[31:0] > f_q) begin
        div_start = 1'b1;
        div_num   = {32'b0, rd_word.coeff[31:0] - f_q};
        div_den   = mirc_pkg::Q_ONE - {32'b0, f_q};
      end
    end
  end

  mirc_ram #(
    .WIDTH ($bits(mirc_pkg::term_t)),
    .DEPTH (mirc_pkg::MAX_TERMS)
  ) u_term_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_word),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mirc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  mirc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= 1'b0;
      max_cuts_q   <= '0;
      tol_q        <= mirc_pkg::TOL_RESET;
      term_count_q <= '0;
      shifted_q    <= '0;
      skip_q       <= 1'b0;
      cuts_made_q  <= '0;
      last_q       <= 1'b0;
      f_q          <= '0;
      rhs_q        <= '0;
      lhs_q        <= '0;
      alpha_q      <= '0;
      add_floor_q  <= 1'b0;
      idx_q        <= '0;
      last_keep_q  <= '0;
      nkeep_q      <= '0;
      out_valid_q  <= 1'b0;
      cut_var_q    <= '0;
      cut_coeff_q  <= '0;
      cut_last_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          mirc_pkg::CFG_MODE:      mode_q     <= cfg_data_i[0];
          mirc_pkg::CFG_MAX_CUTS:  max_cuts_q <= cfg_data_i[15:0];
          mirc_pkg::CFG_TOLERANCE: tol_q      <= cfg_data_i[30:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept_in) begin
            if (new_pass_i) begin
              cuts_made_q <= '0;
            end
            shifted_q <= base_rhs;
            skip_q    <= skip_new;
            last_q    <= last_term_i;
            if (!full) begin
              term_count_q <= term_count_q + CW'(1);
            end
            // skip the bound shift when the row is dropped anyway
            if (do_mul) begin
              state_q <= S_TMUL;
            end else if (last_term_i) begin
              state_q <= S_CHECK;
            end
          end
        end

        S_TMUL: begin
          if (mul_done) begin
            shifted_q <= mode_q ? mirc_pkg::sadd(shifted_q, mul_p)
                                : mirc_pkg::ssub(shifted_q, mul_p);
            state_q   <= last_q ? S_CHECK : S_IDLE;
          end
        end

        S_CHECK: begin
          if (row_drop) begin
            term_count_q <= '0;
            shifted_q    <= '0;
            skip_q       <= 1'b0;
            state_q      <= S_IDLE;
          end else begin
            f_q         <= shifted_q[31:0];
            rhs_q       <= mode_q ? mirc_pkg::sneg(floor_sh) : floor_sh;
            lhs_q       <= '0;
            idx_q       <= '0;
            nkeep_q     <= '0;
            last_keep_q <= '0;
            state_q     <= S_RD;
          end
        end

        S_RD: begin
          state_q <= S_ALPHA;
        end

        S_ALPHA: begin
          add_floor_q <= rd_word.int_flag;
          if (rd_word.coeff[63]) begin
            alpha_q <= '0;
            state_q <= S_KEEP;
          end else if (div_start) begin
            state_q <= S_DIVW;
          end else begin
            // integer term whose fraction is at most f
            alpha_q <= floor_a;
            state_q <= S_KEEP;
          end
        end

        S_DIVW: begin
          if (div_done) begin
            alpha_q <= add_floor_q ? mirc_pkg::sadd(floor_a, div_q) : div_q;
            state_q <= S_KEEP;
          end
        end

        S_KEEP: begin
          if (abort_cut) begin
            term_count_q <= '0;
            shifted_q    <= '0;
            skip_q       <= 1'b0;
            state_q      <= S_IDLE;
          end else if (keep) begin
            nkeep_q     <= nkeep_q + NW'(1);
            last_keep_q <= idx_q;
            state_q     <= S_M1;
          end else if (idx_last) begin
            state_q <= S_VIOL;
          end else begin
            idx_q   <= idx_q + CW'(1);
            state_q <= S_RD;
          end
        end

        S_M1: begin
          if (mul_done) begin
            rhs_q   <= mirc_pkg::sadd(rhs_q, mul_p);
            state_q <= S_M2;
          end
        end

        S_M2: begin
          if (mul_done) begin
            lhs_q <= mirc_pkg::sadd(lhs_q, mul_p);
            if (idx_last) begin
              state_q <= S_VIOL;
            end else begin
              idx_q   <= idx_q + CW'(1);
              state_q <= S_RD;
            end
          end
        end

        S_VIOL: begin
          if (nkeep_q == '0 || !viol) begin
            term_count_q <= '0;
            shifted_q    <= '0;
            skip_q       <= 1'b0;
            state_q      <= S_IDLE;
          end else begin
            if (cuts_made_q != 16'hFFFF) begin
              cuts_made_q <= cuts_made_q + 16'd1;
            end
            idx_q   <= '0;
            state_q <= S_ERD;
          end
        end

        S_ERD: begin
          state_q <= S_ECHK;
        end

        S_ECHK: begin
          if (rd_word.int_flag) begin
            out_valid_q <= 1'b1;
            cut_var_q   <= rd_word.var_id;
            cut_coeff_q <= rd_word.coeff;
            cut_last_q  <= emit_last;
            state_q     <= S_EOUT;
          end else begin
            // never past the last kept term, so always advance
            idx_q   <= idx_q + CW'(1);
            state_q <= S_ERD;
          end
        end

        S_EOUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (emit_last) begin
              term_count_q <= '0;
              shifted_q    <= '0;
              skip_q       <= 1'b0;
              state_q      <= S_IDLE;
            end else begin
              idx_q   <= idx_q + CW'(1);
              state_q <= S_ERD;
            end
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign cut_var_o   = cut_var_q;
  assign cut_coeff_o = cut_coeff_q;
  assign cut_rhs_o   = rhs_q;
  assign cut_last_o  = cut_last_q;

  a_no_input_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input taken while a cut item is pending");

  a_row_closed_after_cut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && cut_last_o) |=> (term_count_q == '0 && in_ready_o))
    else $error("row not closed after final cut item");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_count_q <= CW'(mirc_pkg::MAX_TERMS))
    else $error("term count beyond buffer depth");

  a_cuts_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cuts_made_q != $past(cuts_made_q)) |->
      (cuts_made_q == '0 || cuts_made_q == $past(cuts_made_q) + 16'd1))
    else $error("cut counter moved by more than one");

endmodule

// ===== hdl/mirc_ram.sv =====
module mirc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mirc_mul.sv =====
// Q32.32 saturating multiply on one 32x32 multiplier, four partial products.
module mirc_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               done_o,
  output logic signed [63:0] p_o
);

  logic [63:0]        ua_q, ub_q;
  logic               neg_q;
  logic [127:0]       acc_q;
  logic [63:0]        pp_q;
  logic [1:0]         pk_q;
  logic               pv_q;
  logic [2:0]         cnt_q;
  logic               busy_q;
  logic               done_q;
  logic signed [63:0] p_q;

  logic [31:0]  x, y;
  logic [127:0] pp_sh;
  logic [63:0]  r, lim;
  logic         sat;

  always_comb begin
    x = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
    y = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
    unique case (pk_q)
      2'd0:    pp_sh = {64'b0, pp_q};
      2'd3:    pp_sh = {pp_q, 64'b0};
      default: pp_sh = {32'b0, pp_q, 32'b0};
    endcase
    r   = acc_q[95:32];
    lim = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    sat = (|acc_q[127:96]) || (r > lim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pv_q   <= 1'b0;
      cnt_q  <= '0;
      ua_q   <= '0;
      ub_q   <= '0;
      neg_q  <= 1'b0;
      acc_q  <= '0;
      pp_q   <= '0;
      pk_q   <= '0;
      p_q    <= '0;
    end else if (start_i) begin
      ua_q   <= a_i[63] ? 64'(-a_i) : a_i;
      ub_q   <= b_i[63] ? 64'(-b_i) : b_i;
      neg_q  <= a_i[63] ^ b_i[63];
      acc_q  <= '0;
      cnt_q  <= '0;
      pv_q   <= 1'b0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      if (cnt_q < 3'd4) begin
        pp_q <= x * y;
        pk_q <= cnt_q[1:0];
        pv_q <= 1'b1;
      end else begin
        pv_q <= 1'b0;
      end
      if (pv_q) begin
        acc_q <= acc_q + pp_sh;
      end
      if (cnt_q == 3'd5) begin
        // truncate toward zero, then saturate
        if (sat) begin
          p_q <= neg_q ? mirc_pkg::Q_MIN : mirc_pkg::Q_MAX;
        end else begin
          p_q <= neg_q ? -r : r;
        end
        done_q <= 1'b1;
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + 3'd1;
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

// ===== hdl/mirc_div.sv =====
// Q32.32 quotient of non-negative operands, one restoring step per cycle.
module mirc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [63:0]        num_i,
  input  logic [63:0]        den_i,
  output logic               done_o,
  output logic signed [63:0] quo_o
);

  logic [63:0] nsh_q, den_q, r_q, q_q;
  logic        ovf_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  logic [64:0] rs, rd;
  logic        ge;

  always_comb begin
    rs = {r_q, nsh_q[63]};
    rd = rs - {1'b0, den_q};
    ge = (rs >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      nsh_q  <= '0;
      den_q  <= '0;
      r_q    <= '0;
      q_q    <= '0;
      ovf_q  <= 1'b0;
    end else if (start_i) begin
      nsh_q  <= num_i;
      den_q  <= den_i;
      r_q    <= '0;
      q_q    <= '0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      // 64 numerator bits, then 32 zero bits for the fraction
      r_q   <= ge ? rd[63:0] : rs[63:0];
      q_q   <= {q_q[62:0], ge};
      ovf_q <= ovf_q | q_q[63];
      nsh_q <= {nsh_q[62:0], 1'b0};
      cnt_q <= cnt_q + 7'd1;
      if (cnt_q == 7'd95) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quo_o  = (ovf_q || q_q[63]) ? mirc_pkg::Q_MAX : q_q;

endmodule

// ===== tb/tb_mixed_integer_rounding_cut.sv =====
module tb_mixed_integer_rounding_cut;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles of quiet left after the last result before a register write or the
  // end: a row that yields no cut still runs its rounding pass.
  localparam int SETTLE_CYCLES = 6000;
  // Idle cycles allowed without any handshake before giving up.
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int ITEMS_PER_SETTING = 58;

  typedef struct {
    logic [31:0]        var_id;
    logic signed [63:0] coeff;
    logic signed [63:0] bound;
    logic               inf;
    logic               is_int;
    logic signed [63:0] lp;
    logic signed [63:0] rhs;
    logic [1:0]         sense;
    logic               last;
    logic               new_pass;
  } term_item_t;

  typedef struct {
    logic [31:0]        var_id;
    logic signed [63:0] coeff;
    logic signed [63:0] rhs;
    logic               last;
  } cut_term_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = mirc_pkg::CFG_MODE;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [31:0]        var_id_i = '0;
  logic signed [63:0] term_coeff_i = '0;
  logic signed [63:0] var_bound_i = '0;
  logic               bound_infinite_i = 1'b0;
  logic               is_integer_i = 1'b0;
  logic signed [63:0] lp_value_i = '0;
  logic signed [63:0] row_rhs_i = '0;
  logic [1:0]         row_sense_i = '0;
  logic               last_term_i = 1'b0;
  logic               new_pass_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [31:0]        cut_var_o;
  logic signed [63:0] cut_coeff_o;
  logic signed [63:0] cut_rhs_o;
  logic               cut_last_o;

  mixed_integer_rounding_cut u_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Configuration as the block should hold it.
  logic        mode_cfg = 1'b0;
  int          max_cuts_cfg = 0;
  logic [30:0] tol_cfg = mirc_pkg::TOL_RESET;

  // Row being collected by the predictor.
  term_item_t         row_terms[mirc_pkg::MAX_TERMS];
  int                 row_len = 0;
  logic signed [63:0] row_b = '0;
  bit                 row_bad = 1'b0;
  int                 cuts_made = 0;

  term_item_t pending_terms[$];
  cut_term_t  expected_cut[$];

  int  n_terms = 0, n_rows = 0, n_cuts = 0, n_results = 0, n_errors = 0;
  bit  drive_valid;
  int  burst_left = 0, gap_left = 0;
  int  ready_pct = 100, ready_run = 0;
  int  idle_cycles = 0;

  // ---------------------------------------------------------------- Q32.32 math
  function automatic logic signed [63:0] qadd(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return mirc_pkg::Q_MAX;
    if (s < -65'sh0_8000_0000_0000_0000) return mirc_pkg::Q_MIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] qsub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return mirc_pkg::Q_MAX;
    if (s < -65'sh0_8000_0000_0000_0000) return mirc_pkg::Q_MIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] qneg(logic signed [63:0] a);
    return (a == mirc_pkg::Q_MIN) ? mirc_pkg::Q_MAX : -a;
  endfunction

  // Product magnitude truncated toward zero, then saturated.
  function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
    logic [63:0]  ua, ub, r;
    logic [127:0] p;
    bit           neg;
    neg = a[63] ^ b[63];
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    r = p[95:32];
    if (p[127:96] != 0) return neg ? mirc_pkg::Q_MIN : mirc_pkg::Q_MAX;
    if (neg ? (r > 64'h8000_0000_0000_0000) : (r > 64'h7FFF_FFFF_FFFF_FFFF))
      return neg ? mirc_pkg::Q_MIN : mirc_pkg::Q_MAX;
    return neg ? -r : r;
  endfunction

  function automatic logic signed [63:0] qdiv(logic signed [63:0] n, logic signed [63:0] d);
    logic [127:0] q;
    if (n < 0 || d <= 0) return '0;
    q = {32'd0, n, 32'd0} / {64'd0, d};
    if (q > 128'h7FFF_FFFF_FFFF_FFFF) return mirc_pkg::Q_MAX;
    return q[63:0];
  endfunction

  function automatic logic signed [63:0] rounded_coeff(logic signed [63:0] a,
                                                       logic signed [63:0] f, logic is_int);
    logic signed [63:0] fa, fl;
    if (a < 0) return '0;
    if (!is_int) return qdiv(a, f);
    fa = {32'd0, a[31:0]};
    fl = {a[63:32], 32'd0};
    if (fa <= f) return fl;
    return qadd(fl, qdiv(fa - f, mirc_pkg::Q_ONE - f));
  endfunction

  // Take one accepted term; on the row's last term, queue the cut it yields.
  task automatic predict_cut_terms(input term_item_t t);
    logic signed [63:0] f, rhs, lhs, al, tolq;
    cut_term_t          kept[$];
    bit                 drop, violated;
    tolq = {33'd0, tol_cfg};
    if (t.new_pass) cuts_made = 0;
    if (row_len == 0) row_b = mode_cfg ? qneg(t.rhs) : t.rhs;
    if (t.sense != {1'b0, mode_cfg}) row_bad = 1'b1;
    if (row_len >= mirc_pkg::MAX_TERMS) begin
      row_bad = 1'b1;
    end else begin
      row_terms[row_len] = t;
      row_len++;
    end
    if (!mode_cfg) begin
      if (t.inf) row_bad = 1'b1;
      else row_b = qsub(row_b, qmul(t.coeff, t.bound));
    end else begin
      if (t.inf || t.coeff <= 0) row_bad = 1'b1;
      else row_b = qadd(row_b, qmul(t.coeff, t.bound));
    end
    if (!t.last) return;
    n_rows++;
    f = {32'd0, row_b[31:0]};
    drop = row_bad || (max_cuts_cfg != 0 && cuts_made >= max_cuts_cfg) ||
           (mode_cfg && row_b < 0) || f <= tolq || f >= mirc_pkg::Q_ONE - tolq;
    if (!drop) begin
      rhs = {row_b[63:32], 32'd0};
      if (mode_cfg) rhs = qneg(rhs);
      lhs = '0;
      for (int i = 0; i < row_len; i++) begin
        al = rounded_coeff(row_terms[i].coeff, f, row_terms[i].is_int);
        if (al > tolq) begin
          kept.insert(kept.size(),
                      '{var_id: row_terms[i].var_id, coeff: al, rhs: '0, last: 1'b0});
          rhs = qadd(rhs, qmul(al, row_terms[i].bound));
          lhs = qadd(lhs, qmul(al, row_terms[i].lp));
        end
      end
      violated = mode_cfg ? (lhs < qsub(rhs, tolq)) : (lhs > qadd(rhs, tolq));
      if (kept.size() > 0 && violated) begin
        foreach (kept[i]) begin
          kept[i].rhs = rhs;
          kept[i].last = (i == kept.size() - 1);
          expected_cut.insert(expected_cut.size(), kept[i]);
        end
        if (cuts_made < 65535) cuts_made++;
        n_cuts++;
      end
    end
    row_len = 0;
    row_b = '0;
    row_bad = 1'b0;
  endtask

  // ---------------------------------------------------------------- driver
  // Send terms in bursts of random length; hold valid and payload until taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      drive_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_cut_terms(pending_terms.pop_front());
        n_terms++;
        drive_valid = 1'b0;
      end
      if (!drive_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_terms.size() > 0) begin
          var_id_i         <= pending_terms[0].var_id;
          term_coeff_i     <= pending_terms[0].coeff;
          var_bound_i      <= pending_terms[0].bound;
          bound_infinite_i <= pending_terms[0].inf;
          is_integer_i     <= pending_terms[0].is_int;
          lp_value_i       <= pending_terms[0].lp;
          row_rhs_i        <= pending_terms[0].rhs;
          row_sense_i      <= pending_terms[0].sense;
          last_term_i      <= pending_terms[0].last;
          new_pass_i       <= pending_terms[0].new_pass;
          drive_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            // a quarter of the bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid_i <= drive_valid;
    end
  end

  // ---------------------------------------------------------------- monitor
  // Check each cut item against the prediction; stall the receiver at a rate that changes after runs of random length.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (expected_cut.size() == 0) begin
          $error("cut item with none expected: var %0h coeff %0h", cut_var_o, cut_coeff_o);
          n_errors++;
        end else begin
          automatic cut_term_t e = expected_cut.pop_front();
          if (cut_var_o !== e.var_id) begin
            $error("cut_var expected %0h actual %0h", e.var_id, cut_var_o);
            n_errors++;
          end
          if (cut_coeff_o !== e.coeff) begin
            $error("cut_coeff expected %0h actual %0h", e.coeff, cut_coeff_o);
            n_errors++;
          end
          if (cut_rhs_o !== e.rhs) begin
            $error("cut_rhs expected %0h actual %0h", e.rhs, cut_rhs_o);
            n_errors++;
          end
          if (cut_last_o !== e.last) begin
            $error("cut_last expected %0b actual %0b", e.last, cut_last_o);
            n_errors++;
          end
        end
      end
      if (ready_run == 0) begin
        ready_run = $urandom_range(50, 300);
        case ($urandom_range(0, 2))
          0: ready_pct = 100;
          1: ready_pct = 70;
          default: ready_pct = 30;
        endcase
      end else begin
        ready_run--;
      end
      out_ready_i <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [63:0] qval(int ip, logic [31:0] fr);
    return {ip[31:0], fr};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_term(logic [31:0] v, logic signed [63:0] a, logic signed [63:0] b,
                           logic inf, logic is_int, logic signed [63:0] lp,
                           logic signed [63:0] rhs, logic [1:0] sense, logic last,
                           logic np);
    pending_terms.insert(pending_terms.size(),
                         '{var_id: v, coeff: a, bound: b, inf: inf, is_int: is_int,
                           lp: lp, rhs: rhs, sense: sense, last: last, new_pass: np});
  endtask

  // Queue one row; mostly well formed for the current mode, with random
  // content, else pure noise. Returns the number of terms queued.
  task automatic push_row(output int len);
    logic signed [63:0] rhs, a, b, lp;
    logic [1:0]         sense;
    bit                 noise;
    noise = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 39))
      0: len = mirc_pkg::MAX_TERMS;
      1: len = $urandom_range(mirc_pkg::MAX_TERMS + 1, mirc_pkg::MAX_TERMS + 3);
      default: len = $urandom_range(1, 6);
    endcase
    rhs = mode_cfg ? qval($urandom_range(0, 10) - 6, $urandom)
                   : qval($urandom_range(0, 24) - 4, $urandom);
    if (noise) rhs = rand64();
    for (int i = 0; i < len; i++) begin
      if (noise) begin
        push_term($urandom, rand64(), rand64(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), rand64(), rand64(),
                  2'($urandom_range(0, 3)), i == len - 1, 1'($urandom_range(0, 1)));
      end else begin
        a = qval($urandom_range(0, 6), $urandom);
        if ($urandom_range(0, 19) == 0) a = -a;
        if (mode_cfg) begin
          b = qval($urandom_range(2, 6), ($urandom_range(0, 1) != 0) ? $urandom : 32'd0);
          lp = b - qval($urandom_range(0, 3), $urandom);
        end else begin
          b = qval($urandom_range(0, 3), ($urandom_range(0, 1) != 0) ? $urandom : 32'd0);
          lp = b + qval($urandom_range(0, 3), $urandom);
        end
        sense = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3)) : {1'b0, mode_cfg};
        push_term($urandom, a, b, $urandom_range(0, 29) == 0, $urandom_range(0, 9) < 7,
                  lp, rhs, sense, i == len - 1, $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // Extremes of each field and the skip cases, in plain rounding mode.
  task automatic push_directed();
    // single integer term with a half fraction on the right-hand side
    push_term(32'h0, mirc_pkg::Q_MAX, '0, 1'b0, 1'b1, mirc_pkg::Q_MAX,
              qval(0, 32'h8000_0000), 2'd0, 1'b1, 1'b0);
    // saturating products and sums
    push_term(32'hFFFF_FFFF, mirc_pkg::Q_MIN, mirc_pkg::Q_MIN, 1'b0, 1'b1, mirc_pkg::Q_MIN,
              mirc_pkg::Q_MIN, 2'd0, 1'b0, 1'b1);
    push_term(32'hA5A5_5A5A, mirc_pkg::Q_MAX, mirc_pkg::Q_MAX, 1'b0, 1'b0, mirc_pkg::Q_MAX,
              mirc_pkg::Q_MIN, 2'd0, 1'b1, 1'b0);
    // continuous term with a fractional part; negative coefficient left out
    push_term(32'h1234, qval(2, 32'h4000_0000), qval(1, 0), 1'b0, 1'b0, qval(9, 0),
              qval(5, 32'h3000_0000), 2'd0, 1'b0, 1'b0);
    push_term(32'h5678, qval(-3, 0), qval(0, 0), 1'b0, 1'b1, qval(4, 0),
              qval(5, 32'h3000_0000), 2'd0, 1'b1, 1'b0);
    // wrong sense, other sense, unused sense code
    push_term(32'h1, qval(1, 1), '0, 1'b0, 1'b1, qval(3, 0), qval(1, 32'h8000_0000),
              2'd1, 1'b1, 1'b0);
    push_term(32'h2, qval(1, 1), '0, 1'b0, 1'b1, qval(3, 0), qval(1, 32'h8000_0000),
              2'd2, 1'b1, 1'b0);
    push_term(32'h3, qval(1, 1), '0, 1'b0, 1'b1, qval(3, 0), qval(1, 32'h8000_0000),
              2'd3, 1'b1, 1'b0);
    // infinite bound
    push_term(32'h4, qval(2, 7), qval(1, 0), 1'b1, 1'b1, qval(3, 0), qval(3, 32'h8000_0000),
              2'd0, 1'b1, 1'b0);
    // integral right-hand side that the shift makes fractional
    push_term(32'h5, qval(1, 32'h9000_0000), qval(2, 0), 1'b0, 1'b1, qval(6, 0), qval(7, 0),
              2'd0, 1'b0, 1'b0);
    push_term(32'h6, qval(3, 0), qval(0, 0), 1'b0, 1'b1, qval(6, 0), qval(7, 0),
              2'd0, 1'b1, 1'b0);
    // fraction just at the tolerance
    push_term(32'h7, qval(1, 0), qval(0, 0), 1'b0, 1'b1, qval(5, 0), qval(2, 4295),
              2'd0, 1'b1, 1'b1);
    push_term(32'h8, qval(1, 0), qval(0, 0), 1'b0, 1'b1, qval(5, 0), qval(2, -4295),
              2'd0, 1'b1, 1'b0);
    // cut not violated by the LP point
    push_term(32'h9, qval(1, 32'h2000_0000), qval(0, 0), 1'b0, 1'b1, qval(0, 0),
              qval(3, 32'h6000_0000), 2'd0, 1'b1, 1'b0);
  endtask

  task automatic wait_quiet();
    while (pending_terms.size() != 0 || in_valid_i || expected_cut.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(mirc_pkg::cfg_idx_t idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      mirc_pkg::CFG_MODE:     mode_cfg = data[0];
      mirc_pkg::CFG_MAX_CUTS: max_cuts_cfg = data[15:0];
      default:                tol_cfg = data[30:0];
    endcase
  endtask

  initial begin
    // mode, max_cuts, tolerance per phase; the first keeps the reset values
    automatic logic [31:0] plan[6][3] = '{
      '{0, 0, 32'(mirc_pkg::TOL_RESET)}, '{1, 0, 32'(mirc_pkg::TOL_RESET)}, '{0, 2, 0},
      '{1, 65535, 32'hFFFF_FFFF}, '{0, 1, 32'h0010_0000}, '{1, 3, 0}};
    int queued, len;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        wait_quiet();
        write_reg(mirc_pkg::CFG_MODE, plan[p][0]);
        write_reg(mirc_pkg::CFG_MAX_CUTS, plan[p][1]);
        write_reg(mirc_pkg::CFG_TOLERANCE, plan[p][2]);
      end
      queued = 0;
      if (p == 0) push_directed();
      while (queued < ITEMS_PER_SETTING) begin
        push_row(len);
        queued += len;
        // hold the sender once per phase until every cut has come back
        if (queued >= ITEMS_PER_SETTING / 2 && queued - len < ITEMS_PER_SETTING / 2)
          while (pending_terms.size() != 0 || in_valid_i || expected_cut.size() != 0)
            @(posedge clk_i);
      end
    end
    wait_quiet();
    $display("Covered %0d terms in %0d rows over six settings of mode, cut limit",
             n_terms, n_rows);
    $display("and tolerance; %0d cuts came out as %0d checked cut items.", n_cuts, n_results);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
